// ----- src/homing_velocity_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Homing velocity unit assertion macros
// Concurrent assertion wrappers on clk and rst, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef HOMING_VELOCITY_UNIT_DEFINES_SVH
`define HOMING_VELOCITY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define HVU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define HVU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HVU_ASSERT(lbl, cond, msg)
`define HVU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/hvu_pkg.sv -----
// ----------------------------------------------------------------------------
// Homing velocity unit package
// Shared widths, item class codes and the word types between the parts.
// ----------------------------------------------------------------------------
package hvu_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = 25;
  localparam int DistW  = 50;

  localparam logic [1:0] CLS_SKIP = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_RUN  = 2'd2;

  localparam logic REG_SPEED       = 1'b0;
  localparam logic REG_MIN_DIST_SQ = 1'b1;

  typedef struct packed {
    logic [1:0]              cls;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
    logic [DistW-1:0]        d2;
  } hvu_item_t;

  typedef struct packed {
    logic                     wr;
    logic signed [CoordW-1:0] vx;
    logic signed [CoordW-1:0] vy;
    logic signed [CoordW-1:0] vz;
  } hvu_result_t;

  typedef struct packed {
    logic [CoordW-1:0] speed;
    logic [CoordW-1:0] min_dist_sq;
  } hvu_cfg_t;

endpackage

// ----- src/hvu_queue.sv -----
// ----------------------------------------------------------------------------
// Homing velocity unit item queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module hvu_queue import hvu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  hvu_item_t                    item_in,
  input  logic                         pop,
  output hvu_item_t                    item_out,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  hvu_item_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign empty    = (count == '0);
  assign item_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- src/hvu_front.sv -----
// ----------------------------------------------------------------------------
// Homing velocity unit front end
// Takes words, forms the offsets and squared distance, and classifies them.
// ----------------------------------------------------------------------------
module hvu_front import hvu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        self_present,
  input  logic                        target_present,
  input  logic signed [CoordW-1:0]    self_x,
  input  logic signed [CoordW-1:0]    self_y,
  input  logic signed [CoordW-1:0]    self_z,
  input  logic signed [CoordW-1:0]    target_x,
  input  logic signed [CoordW-1:0]    target_y,
  input  logic signed [CoordW-1:0]    target_z,
  input  logic [CoordW-1:0]           min_dist_sq,
  input  logic [$clog2(DEPTH+1)-1:0]  q_count,
  output logic                        q_push,
  output hvu_item_t                   q_item
);

  localparam int CW = $clog2(DEPTH+1);

  logic                    v1;
  logic                    sp1;
  logic                    tp1;
  logic signed [DiffW-1:0] dx1;
  logic signed [DiffW-1:0] dy1;
  logic signed [DiffW-1:0] dz1;
  logic                    v2;
  logic                    sp2;
  logic                    tp2;
  logic signed [DiffW-1:0] dx2;
  logic signed [DiffW-1:0] dy2;
  logic signed [DiffW-1:0] dz2;
  logic [DistW-2:0]        sqx;
  logic [DistW-2:0]        sqy;
  logic [DistW-2:0]        sqz;
  logic signed [DistW-1:0] px;
  logic signed [DistW-1:0] py;
  logic signed [DistW-1:0] pz;
  logic [CW:0]             used;
  logic                    accept;
  logic [DistW-1:0]        d2;

  assign used   = (CW+1)'(q_count) + (CW+1)'(v1) + (CW+1)'(v2);
  assign full   = (used >= (CW+1)'(DEPTH));
  assign accept = push && !full;

  assign px = dx1 * dx1;
  assign py = dy1 * dy1;
  assign pz = dz1 * dz1;

  assign d2 = {1'b0, sqx} + {1'b0, sqy} + {1'b0, sqz};

  always_comb begin
    q_item.dx = dx2;
    q_item.dy = dy2;
    q_item.dz = dz2;
    q_item.d2 = d2;
    if (!sp2) begin
      q_item.cls = CLS_SKIP;
    end else if (!tp2 || d2 == '0 || d2 < DistW'(min_dist_sq)) begin
      q_item.cls = CLS_ZERO;
    end else begin
      q_item.cls = CLS_RUN;
    end
  end

  assign q_push = v2;

  always_ff @(posedge clk) begin
    dx1 <= DiffW'(target_x) - DiffW'(self_x);
    dy1 <= DiffW'(target_y) - DiffW'(self_y);
    dz1 <= DiffW'(target_z) - DiffW'(self_z);
    sp1 <= self_present;
    tp1 <= target_present;
    sqx <= px[DistW-2:0];
    sqy <= py[DistW-2:0];
    sqz <= pz[DistW-2:0];
    dx2 <= dx1;
    dy2 <= dy1;
    dz2 <= dz1;
    sp2 <= sp1;
    tp2 <= tp1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

endmodule

// ----- src/hvu_back.sv -----
// ----------------------------------------------------------------------------
// Homing velocity unit back end
// Normalizes, takes the square root and divides to scale each word.
// ----------------------------------------------------------------------------
module hvu_back import hvu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CoordW-1:0] speed,
  input  logic              q_empty,
  input  hvu_item_t         q_item,
  output logic              q_pop,
  output logic              out_valid,
  output hvu_result_t       out_res,
  input  logic              pop
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int TW = 62;
  localparam int RW = 31;
  localparam int PW = 55;
  localparam int QW = 24;

  logic [2:0]         state;
  logic [1:0]         cls;
  logic [2:0]         neg;
  logic [DiffW-1:0]   mag [3];
  logic [TW-1:0]      t;
  logic [4:0]         k;
  logic [4:0]         cnt;
  logic [RW+1:0]      rem;
  logic [RW-1:0]      root;
  logic [PW-1:0]      prod [3];
  logic [RW-1:0]      drem [3];
  logic [QW-1:0]      quo [3];
  logic [RW+3:0]      rem_sh;
  logic [RW+3:0]      trial;
  logic               out_free;
  logic signed [DiffW-1:0] din [3];

  function automatic logic [CoordW-1:0] sat_apply(input logic n, input logic [QW-1:0] m);
    logic [CoordW-1:0] r;
    if (n) begin
      r = (m > 24'd8388608) ? 24'h800000 : (~m + 24'd1);
    end else begin
      r = (m > 24'd8388607) ? 24'h7FFFFF : m;
    end
    return r;
  endfunction

  assign din[0] = q_item.dx;
  assign din[1] = q_item.dy;
  assign din[2] = q_item.dz;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign out_free = !out_valid || pop;
  assign rem_sh   = {rem, t[TW-1:TW-2]};
  assign trial    = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cls <= q_item.cls;
        t   <= TW'(q_item.d2);
        k   <= '0;
        for (int i = 0; i < 3; i++) begin
          neg[i] <= din[i][DiffW-1];
          mag[i] <= din[i][DiffW-1] ? DiffW'(-din[i]) : DiffW'(din[i]);
        end
      end
      ST_NORM: begin
        rem  <= '0;
        root <= '0;
        cnt  <= 5'd30;
        if (t[TW-1:TW-2] == 2'b00) begin
          t <= {t[TW-3:0], 2'b00};
          k <= k + 5'd1;
        end
      end
      ST_SQRT: begin
        if (rem_sh >= trial) begin
          rem  <= (RW+2)'(rem_sh - trial);
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[RW+1:0];
          root <= {root[RW-2:0], 1'b0};
        end
        t   <= {t[TW-3:0], 2'b00};
        cnt <= cnt - 5'd1;
      end
      ST_MUL: begin
        for (int i = 0; i < 3; i++) begin
          prod[i] <= PW'(RW'(PW'(mag[i]) << k)) * PW'(speed);
        end
        cnt <= 5'd23;
      end
      ST_ADD: begin
        for (int i = 0; i < 3; i++) begin
          drem[i] <= RW'((prod[i] + PW'(root[RW-1:1])) >> QW);
          quo[i]  <= QW'(prod[i] + PW'(root[RW-1:1]));
        end
      end
      ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if ({drem[i], quo[i][QW-1]} >= {1'b0, root}) begin
            drem[i] <= RW'({drem[i], quo[i][QW-1]} - {1'b0, root});
            quo[i]  <= {quo[i][QW-2:0], 1'b1};
          end else begin
            drem[i] <= {drem[i][RW-2:0], quo[i][QW-1]};
            quo[i]  <= {quo[i][QW-2:0], 1'b0};
          end
        end
        cnt <= cnt - 5'd1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_res.wr <= (cls != CLS_SKIP);
          if (cls == CLS_RUN) begin
            out_res.vx <= sat_apply(neg[0], quo[0]);
            out_res.vy <= sat_apply(neg[1], quo[1]);
            out_res.vz <= sat_apply(neg[2], quo[2]);
          end else begin
            out_res.vx <= '0;
            out_res.vy <= '0;
            out_res.vz <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= (q_item.cls == CLS_RUN) ? ST_NORM : ST_DONE;
          end
        end
        ST_NORM: begin
          if (t[TW-1:TW-2] != 2'b00) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (cnt == '0) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/homing_velocity_unit.sv -----
// ----------------------------------------------------------------------------
// Homing velocity unit
// Velocity from pursuer toward target, normalized and scaled by speed.
//
// Channel  Direction  Handshake          Contents
// input    in         push / full        presence flags, both positions
// result   out        pop / empty        write flag, velocity x y z
// config   in         cfg_wr_en          cfg_index, cfg_data
//
// The front takes a word every cycle while the queue has room and registers
// the offsets and then their squares. The back handles one word at a time.
// For a velocity, the distance normalization shifts by k bit pairs, k from 6
// to 30, followed by a 31 step square root and a 24 step divider for all
// three axes. A skipped or zero word goes from idle to done. Reset clears the
// queue and all valid flags and restores the register defaults.
// ----------------------------------------------------------------------------
`include "homing_velocity_unit_defines.svh"

module homing_velocity_unit import hvu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [CoordW-1:0]        cfg_data,
  input  logic                     push,
  output logic                     full,
  input  logic                     self_present,
  input  logic                     target_present,
  input  logic signed [CoordW-1:0] self_x,
  input  logic signed [CoordW-1:0] self_y,
  input  logic signed [CoordW-1:0] self_z,
  input  logic signed [CoordW-1:0] target_x,
  input  logic signed [CoordW-1:0] target_y,
  input  logic signed [CoordW-1:0] target_z,
  output logic                     empty,
  input  logic                     pop,
  output logic                     write_velocity,
  output logic signed [CoordW-1:0] vel_x,
  output logic signed [CoordW-1:0] vel_y,
  output logic signed [CoordW-1:0] vel_z
);

  localparam int CW = $clog2(QUEUE_DEPTH+1);

  hvu_cfg_t    cfg;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  logic [CW-1:0] q_count;
  hvu_item_t   q_in;
  hvu_item_t   q_out;
  logic        out_valid;
  hvu_result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed       <= 24'd20480;
      cfg.min_dist_sq <= 24'd17;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SPEED:       cfg.speed       <= cfg_data;
        REG_MIN_DIST_SQ: cfg.min_dist_sq <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hvu_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .self_present   (self_present),
    .target_present (target_present),
    .self_x         (self_x),
    .self_y         (self_y),
    .self_z         (self_z),
    .target_x       (target_x),
    .target_y       (target_y),
    .target_z       (target_z),
    .min_dist_sq    (cfg.min_dist_sq),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  hvu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .pop      (q_pop),
    .item_out (q_out),
    .empty    (q_empty),
    .count    (q_count)
  );

  hvu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .speed     (cfg.speed),
    .q_empty   (q_empty),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (res),
    .pop       (pop)
  );

  assign empty          = !out_valid;
  assign write_velocity = res.wr;
  assign vel_x          = res.vx;
  assign vel_y          = res.vy;
  assign vel_z          = res.vz;

  `HVU_ASSERT(a_no_overflow, !(q_push && !q_pop && q_count == CW'(QUEUE_DEPTH)), "queue overflow")
  `HVU_ASSERT(a_no_underflow, !(q_pop && q_empty), "queue underflow")
  `HVU_ASSERT_NEXT(a_count_up, q_push && !q_pop, q_count == $past(q_count) + CW'(1), "count slip")

endmodule
